// ----- rtl/ffss_pkg.sv -----
// ffss_pkg: shared types and constants of the face-follow servo sequencer
// no dependencies; imported by every module of the block

package ffss_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // fixed field widths
    localparam int ALPHA_W   = 9;
    localparam int DBAND_W   = 16;
    localparam int MS_W      = 16;
    localparam int SPEED_W   = 10;
    localparam int RCOUNT_W  = 4;
    localparam int EVENT_W   = 2;

    // smoothing weight full scale, 1.0 in units of 1/256
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMA_ALPHA     = 3'd0,
        REG_DEADBAND      = 3'd1,
        REG_GRACE_MS      = 3'd2,
        REG_GUARD_TIMEOUT = 3'd3,
        REG_NORMAL_SPEED  = 3'd4,
        REG_RELEASE_SPEED = 3'd5,
        REG_RELEASE_COUNT = 3'd6
    } reg_idx_t;

    // reset values
    localparam logic [ALPHA_W-1:0]  RST_EMA_ALPHA     = 9'd179;
    localparam logic [DBAND_W-1:0]  RST_DEADBAND      = 16'd328;
    localparam logic [MS_W-1:0]     RST_GRACE_MS      = 16'd800;
    localparam logic [MS_W-1:0]     RST_GUARD_TIMEOUT = 16'd5000;
    localparam logic [SPEED_W-1:0]  RST_NORMAL_SPEED  = 10'd500;
    localparam logic [SPEED_W-1:0]  RST_RELEASE_SPEED = 10'd200;
    localparam logic [RCOUNT_W-1:0] RST_RELEASE_COUNT = 4'd2;

    // event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_FOUND = 2'd1,
        EV_LOST  = 2'd2
    } event_t;

    // configuration register set
    typedef struct packed {
        logic [ALPHA_W-1:0]  ema_alpha;
        logic [DBAND_W-1:0]  deadband;
        logic [MS_W-1:0]     grace_ms;
        logic [MS_W-1:0]     guard_timeout_ms;
        logic [SPEED_W-1:0]  normal_speed;
        logic [SPEED_W-1:0]  release_speed;
        logic [RCOUNT_W-1:0] release_count;
    } cfg_t;

endpackage

// ----- rtl/ffss_cfg.sv -----
// ffss_cfg: configuration register file of the face-follow servo sequencer
// depends on ffss_pkg

module ffss_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ffss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffss_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ffss_pkg::cfg_t                   cfg
);
    import ffss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_EMA_ALPHA:     cfg_next.ema_alpha        = cfg_data[ALPHA_W-1:0];
                REG_DEADBAND:      cfg_next.deadband         = cfg_data[DBAND_W-1:0];
                REG_GRACE_MS:      cfg_next.grace_ms         = cfg_data[MS_W-1:0];
                REG_GUARD_TIMEOUT: cfg_next.guard_timeout_ms = cfg_data[MS_W-1:0];
                REG_NORMAL_SPEED:  cfg_next.normal_speed     = cfg_data[SPEED_W-1:0];
                REG_RELEASE_SPEED: cfg_next.release_speed    = cfg_data[SPEED_W-1:0];
                REG_RELEASE_COUNT: cfg_next.release_count    = cfg_data[RCOUNT_W-1:0];
                default: ; // unmapped index, write ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ema_alpha        <= RST_EMA_ALPHA;
            cfg_reg.deadband         <= RST_DEADBAND;
            cfg_reg.grace_ms         <= RST_GRACE_MS;
            cfg_reg.guard_timeout_ms <= RST_GUARD_TIMEOUT;
            cfg_reg.normal_speed     <= RST_NORMAL_SPEED;
            cfg_reg.release_speed    <= RST_RELEASE_SPEED;
            cfg_reg.release_count    <= RST_RELEASE_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/ffss_ema.sv -----
// ffss_ema: one axis of the exponential smoothing filter
// depends on ffss_pkg

module ffss_ema #(
    parameter int COORD_BITS = 16
) (
    input  logic [ffss_pkg::ALPHA_W-1:0] alpha,
    input  logic signed [COORD_BITS-1:0] smooth_in,
    input  logic signed [COORD_BITS-1:0] raw,
    output logic signed [COORD_BITS-1:0] smooth_out
);
    import ffss_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + ALPHA_W + 2;

    logic [ALPHA_W-1:0]     alpha_sat;
    logic signed [DW-1:0]   diff;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   rounded;
    logic signed [PW-1:0]   step_q;
    logic signed [PW-1:0]   sum;

    always_comb begin
        // weights above full scale act as full scale
        alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        diff      = $signed({raw[COORD_BITS-1], raw}) -
                    $signed({smooth_in[COORD_BITS-1], smooth_in});
        prod      = $signed({{(PW-ALPHA_W){1'b0}}, alpha_sat}) *
                    $signed({{(PW-DW){diff[DW-1]}}, diff});
        // round half up, then floor divide by 256
        rounded   = prod + $signed(PW'(128));
        step_q    = rounded >>> 8;
        sum       = $signed({{(PW-COORD_BITS){smooth_in[COORD_BITS-1]}}, smooth_in}) + step_q;
        // result lies between old value and raw, no overflow
        smooth_out = sum[COORD_BITS-1:0];
    end

endmodule

// ----- rtl/ffss_core.sv -----
// ffss_core: tracking state and the per-tick step logic
// depends on ffss_pkg and ffss_ema

module ffss_core #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  ffss_pkg::cfg_t                      cfg,
    input  logic [TIME_BITS-1:0]                now_ms,
    input  logic                                detected,
    input  logic signed [COORD_BITS-1:0]        face_x,
    input  logic signed [COORD_BITS-1:0]        face_y,
    input  logic [TIME_BITS-1:0]                capture_stamp,
    input  logic                                ext_lock,
    output logic                                issue_cmd,
    output logic signed [COORD_BITS-1:0]        target_x,
    output logic signed [COORD_BITS-1:0]        target_y,
    output logic [ffss_pkg::SPEED_W-1:0]        cmd_speed,
    output ffss_pkg::event_t                    event_res,
    output logic                                guard_active,
    output logic                                tracking_mode
);
    import ffss_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int AW   = CW + 1;
    localparam int CMPW = (AW > DBAND_W) ? AW : DBAND_W;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRACK = 2'd1,
        PH_GRACE = 2'd2
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic signed [CW-1:0]    smooth_x_reg, smooth_x_next;
    logic signed [CW-1:0]    smooth_y_reg, smooth_y_next;
    logic signed [CW-1:0]    last_x_reg, last_x_next;
    logic signed [CW-1:0]    last_y_reg, last_y_next;
    logic                    last_valid_reg, last_valid_next;
    logic                    guard_held_reg, guard_held_next;
    logic [TIME_BITS-1:0]    guard_start_reg, guard_start_next;
    logic [TIME_BITS-1:0]    guard_baseline_reg, guard_baseline_next;
    logic [TIME_BITS-1:0]    grace_start_reg, grace_start_next;
    logic [RCOUNT_W-1:0]     soft_left_reg, soft_left_next;

    logic                    release_guard;
    logic [TIME_BITS-1:0]    held_ms;
    logic [TIME_BITS-1:0]    missing_ms;
    logic signed [CW-1:0]    seed_x, seed_y;
    logic signed [CW-1:0]    ema_x, ema_y;
    logic signed [AW-1:0]    dx, dy;
    logic [AW-1:0]           adx, ady;
    logic                    try_cmd;
    logic                    skip;

    assign held_ms    = now_ms - guard_start_reg;
    assign missing_ms = now_ms - grace_start_reg;

    // stamp change or timeout frees the guard
    assign release_guard = guard_held_reg &&
        (((capture_stamp != '0) && (capture_stamp != guard_baseline_reg)) ||
         (held_ms > TIME_BITS'(cfg.guard_timeout_ms)));

    // smoothing starts from the reseeded position on release
    assign seed_x = (release_guard && detected) ? face_x : smooth_x_reg;
    assign seed_y = (release_guard && detected) ? face_y : smooth_y_reg;

    ffss_ema #(.COORD_BITS(CW)) u_ema_x (
        .alpha      (cfg.ema_alpha),
        .smooth_in  (seed_x),
        .raw        (face_x),
        .smooth_out (ema_x)
    );

    ffss_ema #(.COORD_BITS(CW)) u_ema_y (
        .alpha      (cfg.ema_alpha),
        .smooth_in  (seed_y),
        .raw        (face_y),
        .smooth_out (ema_y)
    );

    always_comb begin
        phase_next          = phase_reg;
        smooth_x_next       = smooth_x_reg;
        smooth_y_next       = smooth_y_reg;
        last_x_next         = last_x_reg;
        last_y_next         = last_y_reg;
        last_valid_next     = last_valid_reg;
        guard_held_next     = guard_held_reg;
        guard_start_next    = guard_start_reg;
        guard_baseline_next = guard_baseline_reg;
        grace_start_next    = grace_start_reg;
        soft_left_next      = soft_left_reg;
        try_cmd             = 1'b0;
        skip                = 1'b0;
        issue_cmd           = 1'b0;
        target_x            = '0;
        target_y            = '0;
        cmd_speed           = '0;
        event_res           = EV_NONE;
        dx                  = '0;
        dy                  = '0;
        adx                 = '0;
        ady                 = '0;

        if (release_guard) begin
            guard_held_next = 1'b0;
            soft_left_next  = cfg.release_count;
            if (detected) begin
                smooth_x_next   = face_x;
                smooth_y_next   = face_y;
                last_x_next     = face_x;
                last_y_next     = face_y;
                last_valid_next = 1'b1;
            end
        end

        case (phase_reg)
            PH_TRACK, PH_GRACE: begin
                if (detected) begin
                    phase_next    = PH_TRACK;
                    smooth_x_next = ema_x;
                    smooth_y_next = ema_y;
                    try_cmd       = 1'b1;
                end else if (phase_reg == PH_TRACK) begin
                    phase_next       = PH_GRACE;
                    grace_start_next = now_ms;
                end else if (missing_ms > TIME_BITS'(cfg.grace_ms)) begin
                    phase_next      = PH_IDLE;
                    last_valid_next = 1'b0;
                    guard_held_next = 1'b0;
                    event_res       = EV_LOST;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                phase_next = PH_IDLE;
                if (detected) begin
                    phase_next      = PH_TRACK;
                    smooth_x_next   = face_x;
                    smooth_y_next   = face_y;
                    last_valid_next = 1'b0;
                    if (!guard_held_next) begin
                        guard_baseline_next = capture_stamp;
                        guard_held_next     = 1'b1;
                    end
                    guard_start_next = now_ms;
                    event_res        = EV_FOUND;
                end
            end
        endcase

        if (try_cmd && !guard_held_next && !ext_lock) begin
            dx  = $signed({smooth_x_next[CW-1], smooth_x_next}) -
                  $signed({last_x_next[CW-1], last_x_next});
            dy  = $signed({smooth_y_next[CW-1], smooth_y_next}) -
                  $signed({last_y_next[CW-1], last_y_next});
            adx = dx[AW-1] ? AW'(-dx) : AW'(dx);
            ady = dy[AW-1] ? AW'(-dy) : AW'(dy);
            if (last_valid_next &&
                (CMPW'(adx) < CMPW'(cfg.deadband)) &&
                (CMPW'(ady) < CMPW'(cfg.deadband))) begin
                skip = 1'b1;
            end
            if (!skip) begin
                cmd_speed = cfg.normal_speed;
                if (soft_left_next != '0) begin
                    cmd_speed      = cfg.release_speed;
                    soft_left_next = soft_left_next - RCOUNT_W'(1);
                end
                issue_cmd       = 1'b1;
                target_x        = smooth_x_next;
                target_y        = smooth_y_next;
                last_x_next     = smooth_x_next;
                last_y_next     = smooth_y_next;
                last_valid_next = 1'b1;
            end
        end

        guard_active  = guard_held_next;
        tracking_mode = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            smooth_x_reg       <= '0;
            smooth_y_reg       <= '0;
            last_x_reg         <= '0;
            last_y_reg         <= '0;
            last_valid_reg     <= 1'b0;
            guard_held_reg     <= 1'b0;
            guard_start_reg    <= '0;
            guard_baseline_reg <= '0;
            grace_start_reg    <= '0;
            soft_left_reg      <= '0;
        end else if (step) begin
            phase_reg          <= phase_next;
            smooth_x_reg       <= smooth_x_next;
            smooth_y_reg       <= smooth_y_next;
            last_x_reg         <= last_x_next;
            last_y_reg         <= last_y_next;
            last_valid_reg     <= last_valid_next;
            guard_held_reg     <= guard_held_next;
            guard_start_reg    <= guard_start_next;
            guard_baseline_reg <= guard_baseline_next;
            grace_start_reg    <= grace_start_next;
            soft_left_reg      <= soft_left_next;
        end
    end

endmodule

// ----- rtl/face_follow_servo_sequencer_unit.sv -----
// face_follow_servo_sequencer_unit: top level of the face-follow servo sequencer
// depends on ffss_pkg, ffss_cfg, ffss_core and ffss_ema

// Face-follow servo sequencer. Each input beat is one tracking tick (time,
// face flag, face position, camera capture stamp, external lock) and gives
// exactly one result beat: an optional look-at command with target and speed,
// a face found / face lost event, and the guard and tracking status after the
// tick. Throughput is one tick per clock while results are taken. An accepted
// beat loads the input register; the step logic then fills the result register
// from it once that register is free or its waiting beat is being taken. The
// tracking state is updated in the same cycle the result register loads, so
// each tick sees the state left by the tick before it. The result register is
// a single stage: a new tick enters while a result waits, and the input side
// stalls only when both registers are full and the result is not taken.
// Configuration registers are written through the cfg_ port at any time with
// no wait; writes are meant to land while no tick is in flight. There is no
// clearing pass after reset.

module face_follow_servo_sequencer_unit #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ffss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffss_pkg::CFG_DATA_W-1:0]     cfg_data,

    // tick input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [TIME_BITS-1:0]                s_now_ms,
    input  logic                                s_detected,
    input  logic signed [COORD_BITS-1:0]        s_face_x,
    input  logic signed [COORD_BITS-1:0]        s_face_y,
    input  logic [TIME_BITS-1:0]                s_capture_stamp,
    input  logic                                s_ext_lock,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_issue_cmd,
    output logic signed [COORD_BITS-1:0]        m_target_x,
    output logic signed [COORD_BITS-1:0]        m_target_y,
    output logic [ffss_pkg::SPEED_W-1:0]        m_cmd_speed,
    output logic [ffss_pkg::EVENT_W-1:0]        m_event_res,
    output logic                                m_guard_active,
    output logic                                m_tracking_mode
);
    import ffss_pkg::*;

    cfg_t cfg;

    // input register
    logic                           in_valid_reg, in_valid_next;
    logic [TIME_BITS-1:0]           now_ms_reg;
    logic                           detected_reg;
    logic signed [COORD_BITS-1:0]   face_x_reg;
    logic signed [COORD_BITS-1:0]   face_y_reg;
    logic [TIME_BITS-1:0]           capture_stamp_reg;
    logic                           ext_lock_reg;

    // step logic results
    logic                           issue_cmd_c;
    logic signed [COORD_BITS-1:0]   target_x_c;
    logic signed [COORD_BITS-1:0]   target_y_c;
    logic [SPEED_W-1:0]             cmd_speed_c;
    event_t                         event_res_c;
    logic                           guard_active_c;
    logic                           tracking_mode_c;

    // result register
    logic                           out_valid_reg, out_valid_next;
    logic                           issue_cmd_reg;
    logic signed [COORD_BITS-1:0]   target_x_reg;
    logic signed [COORD_BITS-1:0]   target_y_reg;
    logic [SPEED_W-1:0]             cmd_speed_reg;
    logic [EVENT_W-1:0]             event_res_reg;
    logic                           guard_active_reg;
    logic                           tracking_mode_reg;

    logic                           in_beat;
    logic                           step;

    // a held tick moves on when the result register is free or being drained
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign in_beat = s_valid && s_ready;

    assign in_valid_next  = in_beat ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : ((out_valid_reg && m_ready) ? 1'b0 : out_valid_reg);

    ffss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ffss_core #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .cfg           (cfg),
        .now_ms        (now_ms_reg),
        .detected      (detected_reg),
        .face_x        (face_x_reg),
        .face_y        (face_y_reg),
        .capture_stamp (capture_stamp_reg),
        .ext_lock      (ext_lock_reg),
        .issue_cmd     (issue_cmd_c),
        .target_x      (target_x_c),
        .target_y      (target_y_c),
        .cmd_speed     (cmd_speed_c),
        .event_res     (event_res_c),
        .guard_active  (guard_active_c),
        .tracking_mode (tracking_mode_c)
    );

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload, captured on each accepted beat
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            now_ms_reg        <= s_now_ms;
            detected_reg      <= s_detected;
            face_x_reg        <= s_face_x;
            face_y_reg        <= s_face_y;
            capture_stamp_reg <= s_capture_stamp;
            ext_lock_reg      <= s_ext_lock;
        end
    end

    // result payload, loaded as the tick is stepped
    always_ff @(posedge aclk) begin
        if (step) begin
            issue_cmd_reg     <= issue_cmd_c;
            target_x_reg      <= target_x_c;
            target_y_reg      <= target_y_c;
            cmd_speed_reg     <= cmd_speed_c;
            event_res_reg     <= event_res_c;
            guard_active_reg  <= guard_active_c;
            tracking_mode_reg <= tracking_mode_c;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_issue_cmd     = issue_cmd_reg;
    assign m_target_x      = target_x_reg;
    assign m_target_y      = target_y_reg;
    assign m_cmd_speed     = cmd_speed_reg;
    assign m_event_res     = event_res_reg;
    assign m_guard_active  = guard_active_reg;
    assign m_tracking_mode = tracking_mode_reg;

`ifndef SYNTHESIS
    // no command means all command fields are zero
    a_idle_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_issue_cmd) |->
        (m_target_x == '0 && m_target_y == '0 && m_cmd_speed == '0))
        else $error("command fields nonzero without a command");

    // a command is only issued while tracking and unguarded
    a_cmd_needs_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_issue_cmd) |-> (m_tracking_mode && !m_guard_active &&
        m_event_res == EV_NONE))
        else $error("command issued outside tracking or under guard");

    // face found always takes the guard and enters tracking
    a_found_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_FOUND) |-> (m_tracking_mode && m_guard_active))
        else $error("face found without guard or tracking");

    // face lost drops to idle with the guard released
    a_lost_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_LOST) |-> (!m_tracking_mode && !m_guard_active))
        else $error("face lost while still tracking or guarded");

    // a stalled result beat never gets overwritten
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && !$past(step)))
        else $error("result register loaded while stalled");
`endif

endmodule
